// ----- hw/rtl/sted_pkg.sv -----
// Package for the sensor threshold event detector: item, slot entry and result
// types, action/kind/event codes and slot table constants. No dependencies.
package sted_pkg;

    localparam int SLOTS          = 16;
    localparam int SLOT_AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEFAULT_PERIOD = 30;
    localparam int MS_PER_SEC     = 1000;
    localparam int LIMIT_W        = 26;

    localparam logic [1:0] ACT_REGISTER  = 2'd0;
    localparam logic [1:0] ACT_CONFIGURE = 2'd1;
    localparam logic [1:0] ACT_SAMPLE    = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;
    localparam logic [1:0] KIND_INT  = 2'd2;

    localparam int EV_CHANGE   = 0;
    localparam int EV_LOWER    = 1;
    localparam int EV_UPPER    = 2;
    localparam int EV_PERIODIC = 3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         slot;
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [3:0]         event_mask;
        logic [15:0]        period_sec;
        logic signed [31:0] low_thresh;
        logic signed [31:0] high_thresh;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         mask;
        logic [15:0]        period;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic signed [31:0] last_value;
        logic               below_latch;
        logic               above_latch;
        logic [31:0]        last_report_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [3:0] out_slot;
        logic [3:0] fired_events;
        logic       report;
        logic       status;
    } result_t;

endpackage

// ----- hw/rtl/sted_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sted_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sted_slot_update.sv -----
// Slot read-modify-write datapath: register, configure and sample actions.
// Depends on sted_pkg.
module sted_slot_update (
    input  sted_pkg::item_t   item_i,
    input  sted_pkg::entry_t  entry_i,
    output sted_pkg::entry_t  entry_o,
    output logic              we_o,
    output sted_pkg::result_t res_o
);
    import sted_pkg::*;

    logic               in_range;
    logic               registered;
    logic [3:0]         ev;
    logic               ok;
    logic [31:0]        elapsed;
    logic [LIMIT_W-1:0] limit;

    always_comb begin
        in_range   = (32'(item_i.slot) < 32'(SLOTS));
        registered = in_range && (entry_i.kind != KIND_NONE);
        elapsed    = item_i.now_ms - entry_i.last_report_ms;
        limit      = LIMIT_W'(entry_i.period) * LIMIT_W'(MS_PER_SEC);
        entry_o    = entry_i;
        ev         = '0;
        ok         = 1'b0;

        case (item_i.action)
            ACT_REGISTER: begin
                if (in_range && (item_i.kind == KIND_BOOL || item_i.kind == KIND_INT)) begin
                    ok                     = 1'b1;
                    entry_o.kind           = item_i.kind;
                    entry_o.mask           = 4'(1 << EV_PERIODIC);
                    entry_o.period         = 16'(DEFAULT_PERIOD);
                    entry_o.lower          = '0;
                    entry_o.upper          = '0;
                    entry_o.last_value     = '0;
                    entry_o.below_latch    = 1'b0;
                    entry_o.above_latch    = 1'b0;
                    entry_o.last_report_ms = item_i.now_ms;
                end
            end
            ACT_CONFIGURE: begin
                if (registered) begin
                    ok             = 1'b1;
                    entry_o.mask   = item_i.event_mask;
                    entry_o.period = item_i.period_sec;
                    entry_o.lower  = item_i.low_thresh;
                    entry_o.upper  = item_i.high_thresh;
                end
            end
            ACT_SAMPLE: begin
                if (registered) begin
                    ok = 1'b1;
                    if (entry_i.kind == KIND_BOOL) begin
                        if (32'(item_i.value[0]) != entry_i.last_value) begin
                            ev[EV_CHANGE]      = 1'b1;
                            entry_o.last_value = 32'(item_i.value[0]);
                        end
                    end else begin
                        if (item_i.value < entry_i.lower && !entry_i.below_latch) begin
                            ev[EV_LOWER]        = 1'b1;
                            entry_o.above_latch = 1'b0;
                            entry_o.below_latch = 1'b1;
                        end else if (item_i.value > entry_i.upper && !entry_i.above_latch) begin
                            ev[EV_UPPER]        = 1'b1;
                            entry_o.above_latch = 1'b1;
                            entry_o.below_latch = 1'b0;
                        end else begin
                            if (item_i.value < entry_i.upper) begin
                                entry_o.above_latch = 1'b0;
                            end
                            if (item_i.value > entry_i.lower) begin
                                entry_o.below_latch = 1'b0;
                            end
                        end
                        if (item_i.value != entry_i.last_value) begin
                            ev[EV_CHANGE] = 1'b1;
                        end
                        entry_o.last_value = item_i.value;
                    end
                    if (elapsed > 32'(limit)) begin
                        entry_o.last_report_ms = item_i.now_ms;
                        ev[EV_PERIODIC]        = 1'b1;
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        we_o               = ok;
        res_o.out_slot     = item_i.slot;
        res_o.fired_events = ev & entry_i.mask;
        res_o.report       = |(ev & entry_i.mask);
        res_o.status       = ok ? STATUS_OK : STATUS_ERR;
    end

endmodule

// ----- hw/rtl/sensor_threshold_event_detector_unit.sv -----
// Top level of the sensor threshold event detector: slot table RAM, valid bits,
// control FSM and result register. Depends on sted_pkg, sted_ram, sted_slot_update.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_action .. s_now_ms    | in
//  result  | m_valid m_ready m_out_slot .. m_status  | out
//
// Each item is read from the slot table RAM in ST_IDLE, then updated, written
// back and loaded into the result register in ST_EXEC.
// The result register frees the update stage once an item is taken downstream;
// a stalled result holds the update stage until m_ready.
// Reset (aresetn, synchronous) clears the FSM, the result valid and the slot
// valid bits; an unwritten slot reads as all zero.
module sensor_threshold_event_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_slot,
    input  logic [1:0]  s_kind,
    input  logic signed [31:0] s_value,
    input  logic [3:0]  s_event_mask,
    input  logic [15:0] s_period_sec,
    input  logic signed [31:0] s_low_thresh,
    input  logic signed [31:0] s_high_thresh,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_out_slot,
    output logic [3:0]  m_fired_events,
    output logic        m_report,
    output logic        m_status
);
    import sted_pkg::*;

    state_t             state_reg, state_next;
    item_t              item_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               hit_reg;
    logic               m_valid_reg, m_valid_next;
    result_t            result_reg;

    logic               exec_done;
    logic               accept;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [SLOT_AW-1:0] slot_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             entry_rd;
    entry_t             entry_wr;
    logic               upd_we;
    logic               ram_we;
    result_t            upd_res;

    assign slot_addr = item_reg.slot[SLOT_AW-1:0];
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        exec_done = 1'b0;
        ram_raddr = slot_addr;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = s_slot[SLOT_AW-1:0];
            end
            ST_EXEC: begin
                exec_done = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (ram_we) begin
                valid_reg[slot_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.action      <= s_action;
            item_reg.slot        <= s_slot;
            item_reg.kind        <= s_kind;
            item_reg.value       <= s_value;
            item_reg.event_mask  <= s_event_mask;
            item_reg.period_sec  <= s_period_sec;
            item_reg.low_thresh  <= s_low_thresh;
            item_reg.high_thresh <= s_high_thresh;
            item_reg.now_ms      <= s_now_ms;
            hit_reg              <= valid_reg[s_slot[SLOT_AW-1:0]];
        end
        if (exec_done) begin
            result_reg <= upd_res;
        end
    end

    sted_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (entry_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry_rd = hit_reg ? entry_t'(ram_rdata) : '0;

    sted_slot_update u_update (
        .item_i  (item_reg),
        .entry_i (entry_rd),
        .entry_o (entry_wr),
        .we_o    (upd_we),
        .res_o   (upd_res)
    );

    assign ram_we = exec_done && upd_we;

    assign m_valid        = m_valid_reg;
    assign m_out_slot     = result_reg.out_slot;
    assign m_fired_events = result_reg.fired_events;
    assign m_report       = result_reg.report;
    assign m_status       = result_reg.status;

    a_we_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EXEC))
        else $error("slot table written outside update cycle");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter update");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_done) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished update did not produce a result");

    a_report_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status == STATUS_ERR) |-> (m_fired_events == '0 && !m_report))
        else $error("error result carries events");

endmodule
